[rtl/core/fust_pkg.sv]
// ----------------------------------------------------------------------------
// fust_pkg: shared types and constants of the first unique symbol tracker
// holds payload structs, control structs between modules and default sizes
// ----------------------------------------------------------------------------
`default_nettype none

package fust_pkg;

   localparam longint unsigned MAX_LEN_DEF = 64'd65536;
   localparam int ALPHABET_SIZE_DEF = 256;

   localparam int SYMBOL_W = 8;
   localparam int POS_W = 16;
   localparam int COUNT_W = 2;
   localparam logic [COUNT_W-1:0] COUNT_SAT = 2'd2;

   // candidate queue: one entry per distinct symbol at most
   localparam int FIFO_DEPTH = 256;
   localparam int FIFO_IDX_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_PTR_W = FIFO_IDX_W + 1;

   typedef struct packed {
      logic [SYMBOL_W-1:0] symbol;
      logic                last;
   } req_payload_type;

   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] first_position;
      logic             length_overflow;
      logic             end_of_string;
   } rsp_payload_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic clear;
   } cnt_ctrl_type;

   typedef struct packed {
      logic               is_zero;
      logic               repeated;
      logic [COUNT_W-1:0] next_count;
   } cnt_stat_type;

   typedef struct packed {
      logic push;
      logic pop;
      logic rd_en;
      logic clear;
   } fifo_ctrl_type;

endpackage

`default_nettype wire

[rtl/core/fust_if.sv]
// ----------------------------------------------------------------------------
// fust_if: valid/ready channels of the first unique symbol tracker
// one interface for the symbol stream, one for the answers
// ----------------------------------------------------------------------------
`default_nettype none

interface fust_req_if;
   logic                      valid;
   logic                      ready;
   fust_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface fust_rsp_if;
   logic                      valid;
   logic                      ready;
   fust_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

[rtl/core/fust_count_table.sv]
// ----------------------------------------------------------------------------
// fust_count_table: per-symbol occurrence counts saturating at two
// count memory with flop valid bits, registered read and shared compare
// ----------------------------------------------------------------------------
`default_nettype none

module fust_count_table #(
   parameter int ALPHABET_SIZE = fust_pkg::ALPHABET_SIZE_DEF,
   parameter int SYM_W = $clog2(ALPHABET_SIZE)
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire fust_pkg::cnt_ctrl_type         ctrl,
   input  wire logic [SYM_W-1:0]               rd_addr,
   input  wire logic [SYM_W-1:0]               wr_addr,
   input  wire logic [fust_pkg::COUNT_W-1:0]   wr_data,
   output fust_pkg::cnt_stat_type              stat
);

   logic [fust_pkg::COUNT_W-1:0] cnt_mem [ALPHABET_SIZE];
   logic [ALPHABET_SIZE-1:0]     valid_ff;
   logic [fust_pkg::COUNT_W-1:0] rd_data_ff;
   logic                         rd_hit_ff;
   logic [fust_pkg::COUNT_W-1:0] cur_count;

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         cnt_mem[wr_addr] <= wr_data;
      end
      if (ctrl.rd_en) begin
         rd_data_ff <= cnt_mem[rd_addr];
      end
   end

   // valid bits stand in for the clear after reset and after the last byte
   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         valid_ff  <= '0;
         rd_hit_ff <= 1'b0;
      end else begin
         if (ctrl.wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (ctrl.rd_en) begin
            rd_hit_ff <= valid_ff[rd_addr];
         end
      end
   end

   // shared compare and saturating increment
   always_comb begin
      cur_count = rd_hit_ff ? rd_data_ff : '0;
      stat.is_zero = (cur_count == '0);
      stat.repeated = (cur_count >= fust_pkg::COUNT_SAT);
      stat.next_count = stat.repeated ? fust_pkg::COUNT_SAT
                                      : cur_count + fust_pkg::COUNT_W'(1);
   end

endmodule

`default_nettype wire

[rtl/core/fust_cand_fifo.sv]
// ----------------------------------------------------------------------------
// fust_cand_fifo: queue of first occurrences, symbol and position
// memory with head and tail pointers and a registered head read
// ----------------------------------------------------------------------------
`default_nettype none

module fust_cand_fifo #(
   parameter int ENTRY_W = 24
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire fust_pkg::fifo_ctrl_type ctrl,
   input  wire logic [ENTRY_W-1:0]     push_data,
   output logic [ENTRY_W-1:0]          rd_data,
   output logic                        empty
);

   logic [ENTRY_W-1:0]              fifo_mem [fust_pkg::FIFO_DEPTH];
   logic [fust_pkg::FIFO_PTR_W-1:0] head_ff;
   logic [fust_pkg::FIFO_PTR_W-1:0] tail_ff;
   logic [ENTRY_W-1:0]              rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         fifo_mem[tail_ff[fust_pkg::FIFO_IDX_W-1:0]] <= push_data;
      end
      if (ctrl.rd_en) begin
         rd_data_ff <= fifo_mem[head_ff[fust_pkg::FIFO_IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         head_ff <= '0;
         tail_ff <= '0;
      end else begin
         if (ctrl.push) begin
            tail_ff <= tail_ff + fust_pkg::FIFO_PTR_W'(1);
         end
         if (ctrl.pop) begin
            head_ff <= head_ff + fust_pkg::FIFO_PTR_W'(1);
         end
      end
   end

   assign rd_data = rd_data_ff;
   assign empty = (head_ff == tail_ff);

endmodule

`default_nettype wire

[rtl/core/first_unique_symbol_tracker.sv]
// ----------------------------------------------------------------------------
// first_unique_symbol_tracker: first non-repeating symbol of a byte stream
// per byte: read and update its count, then walk the queue front, dropping
// repeated candidates; the count memory read port serves byte and queue front
// the block takes one byte at a time, the next in the cycle after the answer is
// loaded; loading the answer waits while the receiver still holds the last one
// synchronous reset clears counts, queue pointers, position and overflow
// ----------------------------------------------------------------------------
`default_nettype none

module first_unique_symbol_tracker #(
   parameter longint unsigned MAX_LEN = fust_pkg::MAX_LEN_DEF,
   parameter int ALPHABET_SIZE = fust_pkg::ALPHABET_SIZE_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   fust_req_if.sink        req_bus,
   fust_rsp_if.source      rsp_bus
);

   localparam int SYM_W = $clog2(ALPHABET_SIZE);
   localparam int CNT_W = $clog2(MAX_LEN + 64'd1);
   localparam int ENTRY_W = SYM_W + fust_pkg::POS_W;
   localparam logic [CNT_W-1:0] LEN_LIMIT = CNT_W'(MAX_LEN);
   localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(MAX_LEN - 64'd1);
   localparam int SYM_CODES = 2 ** fust_pkg::SYMBOL_W;

   // sequencer codes
   localparam logic [2:0] ST_IDLE  = 3'd0;  // waiting for a byte
   localparam logic [2:0] ST_COUNT = 3'd1;  // count of new byte read back
   localparam logic [2:0] ST_HEAD  = 3'd2;  // read queue front
   localparam logic [2:0] ST_FRONT = 3'd3;  // front entry back, read its count
   localparam logic [2:0] ST_TEST  = 3'd4;  // drop front if repeated
   localparam logic [2:0] ST_EMIT  = 3'd5;  // hand answer to output register

   logic [2:0]                   state_ff, state_in;
   logic [SYM_W-1:0]             sym_ff, sym_in;
   logic                         last_ff, last_in;
   logic [fust_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic [CNT_W-1:0]             pos_cnt_ff, pos_cnt_in;
   logic                         ovf_ff, ovf_in;
   logic                         found_ff, found_in;
   logic [fust_pkg::POS_W-1:0]   fpos_ff, fpos_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   fust_pkg::rsp_payload_type    rsp_payload_ff, rsp_payload_in;

   // fold of out-of-alphabet symbols, worked out at elaboration
   logic [SYM_W-1:0] fold_lut [SYM_CODES];
   logic [SYM_W-1:0] fold_sym;

   // position of an accepted byte, saturating at the last legal position
   logic             at_limit;
   logic [CNT_W-1:0] pos_raw;
   logic [63:0]      pos_wide;
   logic [fust_pkg::POS_W-1:0] pos_clamp;

   fust_pkg::cnt_ctrl_type       cnt_ctrl;
   fust_pkg::cnt_stat_type       cnt_stat;
   logic [SYM_W-1:0]             cnt_rd_addr;
   fust_pkg::fifo_ctrl_type      fifo_ctrl;
   logic [ENTRY_W-1:0]           fifo_rd_data;
   logic                         fifo_empty;
   logic [SYM_W-1:0]             front_sym;
   logic [fust_pkg::POS_W-1:0]   front_pos;
   logic                         req_xfer;
   logic                         rsp_free;

   for (genvar g = 0; g < SYM_CODES; g++) begin : g_fold
      assign fold_lut[g] = SYM_W'(g % ALPHABET_SIZE);
   end

   assign fold_sym = fold_lut[req_bus.payload.symbol];
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_xfer = req_bus.valid & req_bus.ready;
   assign rsp_free = !rsp_valid_ff || rsp_bus.ready;

   assign front_sym = fifo_rd_data[ENTRY_W-1 -: SYM_W];
   assign front_pos = fifo_rd_data[fust_pkg::POS_W-1:0];

   // count lookups: the new byte while idle, the queue front otherwise
   assign cnt_rd_addr = (state_ff == ST_IDLE) ? fold_sym : front_sym;

   always_comb begin
      at_limit = (pos_cnt_ff >= LEN_LIMIT);
      pos_raw = at_limit ? LAST_POS : pos_cnt_ff;
      pos_wide = 64'(pos_raw);
      pos_clamp = (pos_wide > 64'h0000_0000_0000_FFFF) ? 16'hFFFF
                                                       : pos_wide[15:0];
   end

   fust_count_table #(
      .ALPHABET_SIZE (ALPHABET_SIZE),
      .SYM_W         (SYM_W)
   ) u_count_table (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (cnt_ctrl),
      .rd_addr (cnt_rd_addr),
      .wr_addr (sym_ff),
      .wr_data (cnt_stat.next_count),
      .stat    (cnt_stat)
   );

   fust_cand_fifo #(
      .ENTRY_W (ENTRY_W)
   ) u_cand_fifo (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (fifo_ctrl),
      .push_data ({sym_ff, pos_ff}),
      .rd_data   (fifo_rd_data),
      .empty     (fifo_empty)
   );

   // sequencer: one count lookup per byte, then walk the queue front
   always_comb begin
      state_in = state_ff;
      sym_in = sym_ff;
      last_in = last_ff;
      pos_in = pos_ff;
      pos_cnt_in = pos_cnt_ff;
      ovf_in = ovf_ff;
      found_in = found_ff;
      fpos_in = fpos_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_bus.ready;
      rsp_payload_in = rsp_payload_ff;
      cnt_ctrl = '0;
      fifo_ctrl = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               sym_in = fold_sym;
               last_in = req_bus.payload.last;
               pos_in = pos_clamp;
               cnt_ctrl.rd_en = 1'b1;
               if (at_limit) begin
                  ovf_in = 1'b1;
               end else begin
                  pos_cnt_in = pos_cnt_ff + CNT_W'(1);
               end
               state_in = ST_COUNT;
            end
         end
         ST_COUNT: begin
            // first occurrence joins the queue, count saturates at two
            fifo_ctrl.push = cnt_stat.is_zero;
            cnt_ctrl.wr_en = 1'b1;
            state_in = ST_HEAD;
         end
         ST_HEAD: begin
            if (fifo_empty) begin
               found_in = 1'b0;
               fpos_in = '0;
               state_in = ST_EMIT;
            end else begin
               fifo_ctrl.rd_en = 1'b1;
               state_in = ST_FRONT;
            end
         end
         ST_FRONT: begin
            cnt_ctrl.rd_en = 1'b1;
            state_in = ST_TEST;
         end
         ST_TEST: begin
            if (cnt_stat.repeated) begin
               fifo_ctrl.pop = 1'b1;
               state_in = ST_HEAD;
            end else begin
               found_in = 1'b1;
               fpos_in = front_pos;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_payload_in.found = found_ff;
               rsp_payload_in.first_position = fpos_ff;
               rsp_payload_in.length_overflow = ovf_ff;
               rsp_payload_in.end_of_string = last_ff;
               // string done: counts, queue, position and overflow start over
               if (last_ff) begin
                  cnt_ctrl.clear = 1'b1;
                  fifo_ctrl.clear = 1'b1;
                  pos_cnt_in = '0;
                  ovf_in = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_cnt_ff <= '0;
         ovf_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pos_cnt_ff <= pos_cnt_in;
         ovf_ff <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      sym_ff <= sym_in;
      last_ff <= last_in;
      pos_ff <= pos_in;
      found_ff <= found_in;
      fpos_ff <= fpos_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.payload = rsp_payload_ff;

endmodule

`default_nettype wire
